// ----- design/rbnh_pkg.sv -----
// rbnh_pkg: shared constants, register map and width helpers for ray_box_nearest_hit.
// No dependencies.
package rbnh_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int TOL_W       = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // quotient bits resolved per divider stage
  localparam int DIV_BITS = 2;

  localparam int NUM_AXES  = 3;
  localparam int NUM_FACES = 6;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TOL       = 3'd6;

  function automatic int data_w(int cw);
    return (cw > 32) ? 64 : 32;
  endfunction

  function automatic int reg_shift(int cw);
    return (cw > 32) ? 3 : 2;
  endfunction

  function automatic int addr_w(int cw);
    return reg_shift(cw) + REG_IDX_W;
  endfunction

endpackage

// ----- design/rbnh_regs.sv -----
// rbnh_regs: APB-style configuration registers (box corners, tolerance).
// Depends on rbnh_pkg.
module rbnh_regs import rbnh_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [addr_w(CW)-1:0]    paddr,
  input  logic [data_w(CW)-1:0]    pwdata,
  output logic [data_w(CW)-1:0]    prdata,
  output logic [CW-1:0]            box_min [NUM_AXES],
  output logic [CW-1:0]            box_max [NUM_AXES],
  output logic [TOL_W-1:0]         tolerance
);

  localparam int DW = data_w(CW);
  localparam int RS = reg_shift(CW);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx = paddr[RS +: REG_IDX_W];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_min[k] <= '0;
        box_max[k] <= '0;
      end
      tolerance <= TOL_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_BOX_MIN_X: box_min[0] <= pwdata[CW-1:0];
        REG_BOX_MIN_Y: box_min[1] <= pwdata[CW-1:0];
        REG_BOX_MIN_Z: box_min[2] <= pwdata[CW-1:0];
        REG_BOX_MAX_X: box_max[0] <= pwdata[CW-1:0];
        REG_BOX_MAX_Y: box_max[1] <= pwdata[CW-1:0];
        REG_BOX_MAX_Z: box_max[2] <= pwdata[CW-1:0];
        REG_TOL:       tolerance  <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BOX_MIN_X: prdata = DW'(box_min[0]);
      REG_BOX_MIN_Y: prdata = DW'(box_min[1]);
      REG_BOX_MIN_Z: prdata = DW'(box_min[2]);
      REG_BOX_MAX_X: prdata = DW'(box_max[0]);
      REG_BOX_MAX_Y: prdata = DW'(box_max[1]);
      REG_BOX_MAX_Z: prdata = DW'(box_max[2]);
      REG_TOL:       prdata = DW'(tolerance);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- design/rbnh_face_div.sv -----
// rbnh_face_div: per-face distance t = (plane - origin) * 2^FB / dir as a pipelined
// restoring divider with saturation and the face reject tests. Depends on rbnh_pkg.
module rbnh_face_div import rbnh_pkg::*; #(
  parameter int CW  = COORD_WIDTH_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int BPS = DIV_BITS
) (
  input  logic                   clk,
  input  logic [(CW+BPS-1)/BPS+1:0] en,
  input  logic signed [CW-1:0]   plane,
  input  logic signed [CW-1:0]   org,
  input  logic signed [CW-1:0]   dir,
  input  logic [TOL_W-1:0]       tol,
  output logic [CW-2:0]          t,
  output logic                   keep
);

  localparam int NDS = (CW + BPS - 1) / BPS;
  localparam int NW  = CW + 1 + FB;
  localparam int WX  = (FB + 1 > CW + 1) ? FB + 1 : CW + 1;

  // prep
  logic signed [CW:0] num;
  logic [CW:0]        numabs;
  logic [CW-1:0]      dabs;
  logic [NW-1:0]      nfull;
  logic [WX-1:0]      hx;
  logic [WX-1:0]      dx;

  assign num    = (CW+1)'(plane) - (CW+1)'(org);
  assign numabs = num[CW] ? -num : num;
  assign dabs   = dir[CW-1] ? -dir : dir;
  assign nfull  = {numabs, {FB{1'b0}}};
  assign hx     = WX'(nfull[NW-1:CW]);
  assign dx     = WX'(dabs);

  logic [NW-1:0] n_q    [NDS+1];
  logic [CW-1:0] d_q    [NDS+1];
  logic [CW:0]   r_q    [NDS+1];
  logic [CW-1:0] q_q    [NDS+1];
  logic          ovf_q  [NDS+1];
  logic          neg_q  [NDS+1];
  logic          skip_q [NDS+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_q[0]    <= nfull;
      d_q[0]    <= dabs;
      r_q[0]    <= hx[CW:0];
      q_q[0]    <= '0;
      ovf_q[0]  <= (hx >= dx);
      neg_q[0]  <= (num[CW] != dir[CW-1]) && (num != '0);
      skip_q[0] <= (dabs < CW'(tol)) || (dir == '0);
    end
  end

  for (genvar s = 0; s < NDS; s++) begin : g_stage
    logic [CW:0]   rc [BPS+1];
    logic [CW-1:0] qc [BPS+1];

    assign rc[0] = r_q[s];
    assign qc[0] = q_q[s];

    for (genvar j = 0; j < BPS; j++) begin : g_bit
      localparam int IDX = CW - 1 - s * BPS - j;
      if (IDX >= 0) begin : g_live
        logic [CW:0] rsh;
        logic        ge;
        assign rsh       = {rc[j][CW-1:0], n_q[s][IDX]};
        assign ge        = rsh >= {1'b0, d_q[s]};
        assign rc[j+1]   = ge ? rsh - {1'b0, d_q[s]} : rsh;
        assign qc[j+1]   = qc[j] | (CW'(ge) << IDX);
      end else begin : g_pass
        assign rc[j+1] = rc[j];
        assign qc[j+1] = qc[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s+1]) begin
        n_q[s+1]    <= n_q[s];
        d_q[s+1]    <= d_q[s];
        r_q[s+1]    <= rc[BPS];
        q_q[s+1]    <= qc[BPS];
        ovf_q[s+1]  <= ovf_q[s];
        neg_q[s+1]  <= neg_q[s];
        skip_q[s+1] <= skip_q[s];
      end
    end
  end

  // saturate and reject
  logic [CW-1:0] qf;
  logic          ovf;
  logic          tge;
  logic          kill;
  logic [CW-2:0] tsat;

  assign qf   = q_q[NDS];
  assign ovf  = ovf_q[NDS];
  assign tge  = ovf || (qf >= CW'(tol));
  assign kill = skip_q[NDS] || (neg_q[NDS] && (ovf || qf != '0)) || !tge;
  assign tsat = (ovf || qf[CW-1]) ? {(CW-1){1'b1}} : qf[CW-2:0];

  always_ff @(posedge clk) begin
    if (en[NDS+1]) begin
      t    <= tsat;
      keep <= !kill;
    end
  end

endmodule

// ----- design/rbnh_hit_test.sv -----
// rbnh_hit_test: hit point origin + floor(dir*t) per axis and box bounds check
// with tolerance slack, two stages. Depends on rbnh_pkg.
module rbnh_hit_test import rbnh_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic [1:0]            en,
  input  logic [CW-2:0]         t_in,
  input  logic                  keep_in,
  input  logic signed [CW-1:0]  org [NUM_AXES],
  input  logic signed [CW-1:0]  dir [NUM_AXES],
  input  logic signed [CW-1:0]  bmin [NUM_AXES],
  input  logic signed [CW-1:0]  bmax [NUM_AXES],
  input  logic [TOL_W-1:0]      tol,
  output logic                  cand_valid,
  output logic [CW-2:0]         cand_t
);

  localparam int PA = (2 * CW - FB > CW + 2) ? 2 * CW - FB : CW + 2;
  localparam int PW = PA + 1;

  logic signed [2*CW-1:0] prodc  [NUM_AXES];
  logic signed [2*CW-1:0] prod_q [NUM_AXES];
  logic signed [CW-1:0]   org_q  [NUM_AXES];
  logic [CW-2:0]          t_q;
  logic                   keep_q;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_mul
    assign prodc[k] = dir[k] * $signed({1'b0, t_in});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_q <= prodc;
      org_q  <= org;
      t_q    <= t_in;
      keep_q <= keep_in;
    end
  end

  logic signed [PW-1:0] tol_s;
  logic [NUM_AXES-1:0]  in_box;

  assign tol_s = $signed(PW'(tol));

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_chk
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    assign p         = PW'(prod_q[k] >>> FB) + PW'(org_q[k]);
    assign lo        = PW'(bmin[k]) - tol_s;
    assign hi        = PW'(bmax[k]) + tol_s;
    assign in_box[k] = (p >= lo) && (p <= hi);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cand_valid <= keep_q && (&in_box);
      cand_t     <= t_q;
    end
  end

endmodule

// ----- design/rbnh_min_sel.sv -----
// rbnh_min_sel: nearest of the six face candidates, two registered stages;
// the second is the output register. Depends on rbnh_pkg.
module rbnh_min_sel import rbnh_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic [1:0]    en,
  input  logic          cv [NUM_FACES],
  input  logic [CW-2:0] ct [NUM_FACES],
  output logic          hit,
  output logic [CW-2:0] t_hit
);

  localparam int NP = NUM_FACES / 2;

  logic          pv   [NP];
  logic [CW-2:0] pt   [NP];
  logic          pv_q [NP];
  logic [CW-2:0] pt_q [NP];

  for (genvar i = 0; i < NP; i++) begin : g_pair
    logic take_a;
    assign take_a = cv[2*i] && (!cv[2*i+1] || ct[2*i] <= ct[2*i+1]);
    assign pv[i]  = cv[2*i] || cv[2*i+1];
    assign pt[i]  = take_a ? ct[2*i] : ct[2*i+1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pv_q <= pv;
      pt_q <= pt;
    end
  end

  logic          bv;
  logic [CW-2:0] bt;

  always_comb begin
    bv = 1'b0;
    bt = '0;
    for (int i = 0; i < NP; i++) begin
      if (pv_q[i] && (!bv || pt_q[i] < bt)) begin
        bv = 1'b1;
        bt = pt_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit   <= bv;
      t_hit <= bv ? bt : '0;
    end
  end

endmodule

// ----- design/ray_box_nearest_hit.sv -----
// ray_box_nearest_hit: nearest ray / axis-aligned box hit, six faces in parallel.
// Accepts one ray per cycle unless out_stall holds the pipeline, with the per-face
// pipelined restoring divider resolving two quotient bits a stage.
// Each stage advances when it is empty or the stage after it advances.
// Reset (synchronous) clears all valid bits; box corners reset to 0, tolerance to 7.
// Depends on rbnh_pkg, rbnh_regs, rbnh_face_div, rbnh_hit_test, rbnh_min_sel.
module ray_box_nearest_hit import rbnh_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [addr_w(COORD_WIDTH)-1:0] paddr,
  input  logic [data_w(COORD_WIDTH)-1:0] pwdata,
  output logic [data_w(COORD_WIDTH)-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  origin_x,
  input  logic signed [COORD_WIDTH-1:0]  origin_y,
  input  logic signed [COORD_WIDTH-1:0]  origin_z,
  input  logic signed [COORD_WIDTH-1:0]  dir_x,
  input  logic signed [COORD_WIDTH-1:0]  dir_y,
  input  logic signed [COORD_WIDTH-1:0]  dir_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [COORD_WIDTH-2:0]         t_hit
);

  localparam int CW  = COORD_WIDTH;
  localparam int NDS = (CW + DIV_BITS - 1) / DIV_BITS;
  localparam int NS  = NDS + 6;
  localparam int RS  = NDS + 2;

  assign pready = 1'b1;

  logic [CW-1:0]        box_min_u [NUM_AXES];
  logic [CW-1:0]        box_max_u [NUM_AXES];
  logic signed [CW-1:0] bmin [NUM_AXES];
  logic signed [CW-1:0] bmax [NUM_AXES];
  logic [TOL_W-1:0]     tol;

  rbnh_regs #(.CW(CW)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .box_min   (box_min_u),
    .box_max   (box_max_u),
    .tolerance (tol)
  );

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_box
    assign bmin[k] = $signed(box_min_u[k]);
    assign bmax[k] = $signed(box_max_u[k]);
  end

  // stage flow control
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NS-1];

  // ray carried alongside the divider
  logic signed [CW-1:0] org_in [NUM_AXES];
  logic signed [CW-1:0] dir_in [NUM_AXES];
  logic signed [CW-1:0] org_p  [RS][NUM_AXES];
  logic signed [CW-1:0] dir_p  [RS][NUM_AXES];

  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      org_p[0] <= org_in;
      dir_p[0] <= dir_in;
    end
    for (int s = 1; s < RS; s++) begin
      if (en[s]) begin
        org_p[s] <= org_p[s-1];
        dir_p[s] <= dir_p[s-1];
      end
    end
  end

  logic          cv [NUM_FACES];
  logic [CW-2:0] ct [NUM_FACES];

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    localparam int AX = f / 2;
    logic signed [CW-1:0] plane;
    logic [CW-2:0]        t_f;
    logic                 keep_f;

    if (f % 2 == 0) begin : g_lo
      assign plane = bmin[AX];
    end else begin : g_hi
      assign plane = bmax[AX];
    end

    rbnh_face_div #(.CW(CW), .FB(FRAC_BITS), .BPS(DIV_BITS)) u_div (
      .clk   (clk),
      .en    (en[NDS+1:0]),
      .plane (plane),
      .org   (org_in[AX]),
      .dir   (dir_in[AX]),
      .tol   (tol),
      .t     (t_f),
      .keep  (keep_f)
    );

    rbnh_hit_test #(.CW(CW), .FB(FRAC_BITS)) u_hit (
      .clk        (clk),
      .en         (en[NDS+3:NDS+2]),
      .t_in       (t_f),
      .keep_in    (keep_f),
      .org        (org_p[RS-1]),
      .dir        (dir_p[RS-1]),
      .bmin       (bmin),
      .bmax       (bmax),
      .tol        (tol),
      .cand_valid (cv[f]),
      .cand_t     (ct[f])
    );
  end

  rbnh_min_sel #(.CW(CW)) u_min (
    .clk   (clk),
    .en    (en[NDS+5:NDS+4]),
    .cv    (cv),
    .ct    (ct),
    .hit   (hit),
    .t_hit (t_hit)
  );

endmodule
